// File: rtl/host_bridge_config_space_defines.svh
`ifndef HOST_BRIDGE_CONFIG_SPACE_DEFINES_SVH
`define HOST_BRIDGE_CONFIG_SPACE_DEFINES_SVH

// Concurrent check: consequent must hold in the same cycle as the antecedent.
`define HBCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbcs: same-cycle check failed");

// Concurrent check: consequent must hold in the cycle after the antecedent.
`define HBCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbcs: next-cycle check failed");

`endif

// File: rtl/hbcs_pkg.sv
package hbcs_pkg;

   localparam int unsigned SPACE_DEPTH  = 256;
   localparam int unsigned SPACE_ADDR_W = 8;
   localparam int unsigned BYTE_W       = 8;

   // operation codes
   localparam logic [1:0] OP_READ       = 2'd0;
   localparam logic [1:0] OP_WRITE      = 2'd1;
   localparam logic [1:0] OP_INIT       = 2'd2;
   localparam logic [1:0] OP_SOFT_RESET = 2'd3;

   // special offsets
   localparam logic [7:0] ADDR_COMMAND    = 8'h04;
   localparam logic [7:0] ADDR_STATUS_LO  = 8'h06;
   localparam logic [7:0] ADDR_CACHE_LINE = 8'h0C;
   localparam logic [7:0] ADDR_BAR_LO     = 8'h10;
   localparam logic [7:0] ADDR_BAR_HI     = 8'h33;
   localparam logic [7:0] ADDR_PAM_LO     = 8'h59;
   localparam logic [7:0] ADDR_PAM_HI     = 8'h5F;
   localparam logic [7:0] ADDR_SMRAM      = 8'h72;

   localparam int unsigned PAM_BYTES = 7;

   // command byte rules per chipset
   localparam logic [7:0] CMD_MASK_MODE0  = 8'h40;
   localparam logic [7:0] CMD_FORCE_MODE0 = 8'h06;
   localparam logic [7:0] CMD_MASK_MODE1  = 8'h02;
   localparam logic [7:0] CMD_FORCE_MODE1 = 8'h04;

   // SMRAM byte rules
   localparam logic [7:0] SMRAM_WR_MASK  = 8'h78;
   localparam logic [7:0] SMRAM_FORCE    = 8'h02;
   localparam logic [7:0] SMRAM_OPEN_CLR = 8'hBF;
   localparam logic [7:0] SMRAM_LOCK     = 8'h10;

   // init / default table: identity entries first, reset defaults from DEFAULTS_START
   localparam int unsigned TABLE_LEN      = 29;
   localparam int unsigned TABLE_IDX_W    = 5;
   localparam int unsigned DEFAULTS_START = 6;

   localparam logic [7:0] TABLE_ADDR [TABLE_LEN] = '{
      8'h00, 8'h01, 8'h0B, 8'h02, 8'h03, 8'h08,
      8'h04, 8'h05, 8'h06, 8'h07, 8'h0D, 8'h0F,
      8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
      8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
      8'h72
   };

   localparam logic [7:0] TABLE_DATA_MODE0 [TABLE_LEN] = '{
      8'h86, 8'h80, 8'h06, 8'h37, 8'h12, 8'h00,
      8'h06, 8'h00, 8'h80, 8'h02, 8'h00, 8'h00,
      8'h00, 8'h01, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h10,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h02
   };

   localparam logic [7:0] TABLE_DATA_MODE1 [TABLE_LEN] = '{
      8'h86, 8'h80, 8'h06, 8'h22, 8'h01, 8'h02,
      8'h06, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
      8'h00, 8'h01, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h02
   };

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  address;
      logic [31:0] write_data;
      logic [2:0]  byte_count;
   } hbcs_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [12:0] pam_read_map;
      logic [12:0] pam_write_map;
      logic        mapping_changed;
      logic        smram_enabled;
      logic        smram_open;
      logic        smram_closed;
      logic        smram_conflict;
   } hbcs_rsp_type;

endpackage

// File: rtl/hbcs_ram.sv
module hbcs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/host_bridge_config_space.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   hbcs_req_type (operation, address, data, count)
// rsp      out        rsp_valid/rsp_stall   hbcs_rsp_type (read data, PAM maps, SMRAM state)
// csr      in         csr_write_enable      csr_write_data (chipset mode)
//
// Operation: one item at a time, stepped by a small sequencer round one byte store port.
//   Reads issue then capture each byte, as the RAM read is registered; soft reset and
//   full init write one table entry per cycle.
// Reset: synchronous; clears the valid bits, PAM and SMRAM bytes and the mode register.
// Stalls: req_stall is high from acceptance until the result is parked in the output
//   register; a stalled result only holds up the sequencer's final step.
`include "host_bridge_config_space_defines.svh"

module host_bridge_config_space import hbcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hbcs_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hbcs_rsp_type rsp_payload,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_READ_ISSUE  = 3'd1;
   localparam logic [2:0] ST_READ_CAPT   = 3'd2;
   localparam logic [2:0] ST_WRITE       = 3'd3;
   localparam logic [2:0] ST_TABLE       = 3'd4;
   localparam logic [2:0] ST_DONE        = 3'd5;

   // control
   logic [2:0]              state_ff, state_in;
   logic                    mode_ff, mode_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SPACE_DEPTH-1:0]  valid_ff, valid_in;      // RAM entry written since clear
   logic [7:0]              pam_ff [PAM_BYTES];       // 0x59..0x5F held in flops
   logic [7:0]              pam_in [PAM_BYTES];
   logic [7:0]              smram_ff, smram_in;       // 0x72 held in a flop

   // item context
   logic [1:0]              op_ff, op_in;
   logic [7:0]              addr_ff, addr_in;
   logic [31:0]             wdata_ff, wdata_in;
   logic [2:0]              count_ff, count_in;
   logic [2:0]              byte_idx_ff, byte_idx_in;
   logic [TABLE_IDX_W-1:0]  tab_idx_ff, tab_idx_in;
   logic [31:0]             rdata_ff, rdata_in;
   logic                    changed_ff, changed_in;
   hbcs_rsp_type            rsp_payload_ff, rsp_payload_in;

   // byte datapath
   logic [8:0]              byte_addr;
   logic                    byte_live;
   logic [7:0]              lane_data;
   logic                    cap_is_pam;
   logic [2:0]              cap_pam_sel;
   logic [7:0]              cap_val;

   // the one store port
   logic                    st_en;
   logic [7:0]              st_addr;
   logic [7:0]              st_data;
   logic                    st_is_pam;
   logic [2:0]              st_pam_sel;

   logic                    ram_we;
   logic [7:0]              ram_q;

   logic [7:0]              wr_cmd;
   logic [7:0]              wr_smram;
   logic [12:0]             rmap;
   logic [12:0]             wmap;
   logic                    req_accept;

   hbcs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SPACE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (st_addr),
      .wr_data (st_data),
      .rd_addr (byte_addr[7:0]),
      .rd_data (ram_q)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // current byte: address + index, bit 8 marks past the end of the space
   assign byte_addr = {1'b0, addr_ff} + {6'd0, byte_idx_ff};
   assign byte_live = (byte_idx_ff < count_ff) && !byte_addr[8];
   assign lane_data = wdata_ff[{byte_idx_ff[1:0], 3'b000} +: 8];

   // read source: flop-held bytes, else RAM if written since clear, else zero
   assign cap_is_pam  = (byte_addr[7:0] >= ADDR_PAM_LO) && (byte_addr[7:0] <= ADDR_PAM_HI);
   assign cap_pam_sel = 3'(byte_addr[7:0] - ADDR_PAM_LO);

   always_comb begin
      if (cap_is_pam) begin
         cap_val = pam_ff[cap_pam_sel];
      end else if (byte_addr[7:0] == ADDR_SMRAM) begin
         cap_val = smram_ff;
      end else if (valid_ff[byte_addr[7:0]]) begin
         cap_val = ram_q;
      end else begin
         cap_val = 8'h00;
      end
   end

   // write rules for the command and SMRAM bytes
   assign wr_cmd = mode_ff ? ((lane_data & CMD_MASK_MODE1) | CMD_FORCE_MODE1)
                           : ((lane_data & CMD_MASK_MODE0) | CMD_FORCE_MODE0);

   always_comb begin
      wr_smram = (lane_data & SMRAM_WR_MASK) | SMRAM_FORCE;
      if ((smram_ff & SMRAM_LOCK) != 8'h00) begin
         // locked: open bit cannot be set, lock stays
         wr_smram = (wr_smram & SMRAM_OPEN_CLR) | SMRAM_LOCK;
      end
   end

   // store request
   always_comb begin
      st_en   = 1'b0;
      st_addr = byte_addr[7:0];
      st_data = lane_data;
      if (state_ff == ST_WRITE && byte_live) begin
         st_en = 1'b1;
         if (byte_addr[7:0] == ADDR_COMMAND) begin
            st_data = wr_cmd;
         end else if (byte_addr[7:0] == ADDR_STATUS_LO || byte_addr[7:0] == ADDR_CACHE_LINE) begin
            st_en = 1'b0;
         end else if (byte_addr[7:0] == ADDR_SMRAM) begin
            st_data = wr_smram;
         end
      end else if (state_ff == ST_TABLE) begin
         st_en   = 1'b1;
         st_addr = TABLE_ADDR[tab_idx_ff];
         st_data = mode_ff ? TABLE_DATA_MODE1[tab_idx_ff] : TABLE_DATA_MODE0[tab_idx_ff];
      end
   end

   assign st_is_pam  = (st_addr >= ADDR_PAM_LO) && (st_addr <= ADDR_PAM_HI);
   assign st_pam_sel = 3'(st_addr - ADDR_PAM_LO);
   assign ram_we     = st_en && !st_is_pam && (st_addr != ADDR_SMRAM);

   // PAM maps from the flop copies
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         rmap[2*k]     = pam_ff[k+1][0];
         rmap[2*k + 1] = pam_ff[k+1][4];
         wmap[2*k]     = pam_ff[k+1][1];
         wmap[2*k + 1] = pam_ff[k+1][5];
      end
      rmap[12] = pam_ff[0][4];
      wmap[12] = pam_ff[0][5];
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      rsp_valid_in   = rsp_valid_ff;
      valid_in       = valid_ff;
      pam_in         = pam_ff;
      smram_in       = smram_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      wdata_in       = wdata_ff;
      count_in       = count_ff;
      byte_idx_in    = byte_idx_ff;
      tab_idx_in     = tab_idx_ff;
      rdata_in       = rdata_ff;
      changed_in     = changed_ff;
      rsp_payload_in = rsp_payload_ff;

      if (csr_write_enable) begin
         mode_in = csr_write_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // apply the store port
      if (st_en) begin
         if (st_is_pam) begin
            pam_in[st_pam_sel] = st_data;
            if (state_ff == ST_WRITE && pam_ff[st_pam_sel] != st_data) begin
               changed_in = 1'b1;
            end
         end else if (st_addr == ADDR_SMRAM) begin
            smram_in = st_data;
         end else begin
            valid_in[st_addr] = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_payload.operation;
               addr_in     = req_payload.address;
               wdata_in    = req_payload.write_data;
               count_in    = (req_payload.byte_count > 3'd4) ? 3'd4 : req_payload.byte_count;
               byte_idx_in = 3'd0;
               rdata_in    = 32'd0;
               changed_in  = 1'b0;
               case (req_payload.operation)
                  OP_READ: begin
                     state_in = ST_READ_ISSUE;
                  end
                  OP_WRITE: begin
                     // an access starting in the BAR window is dropped whole
                     if (req_payload.address >= ADDR_BAR_LO
                         && req_payload.address <= ADDR_BAR_HI) begin
                        count_in = 3'd0;
                     end
                     state_in = ST_WRITE;
                  end
                  OP_INIT: begin
                     valid_in   = '0;
                     tab_idx_in = '0;
                     state_in   = ST_TABLE;
                  end
                  default: begin
                     tab_idx_in = TABLE_IDX_W'(DEFAULTS_START);
                     state_in   = ST_TABLE;
                  end
               endcase
            end
         end
         ST_READ_ISSUE: begin
            state_in = byte_live ? ST_READ_CAPT : ST_DONE;
         end
         ST_READ_CAPT: begin
            rdata_in[{byte_idx_ff[1:0], 3'b000} +: 8] = cap_val;
            byte_idx_in = byte_idx_ff + 3'd1;
            state_in    = ST_READ_ISSUE;
         end
         ST_WRITE: begin
            if (byte_live) begin
               byte_idx_in = byte_idx_ff + 3'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TABLE: begin
            if (tab_idx_ff == TABLE_IDX_W'(TABLE_LEN - 1)) begin
               state_in = ST_DONE;
            end else begin
               tab_idx_in = tab_idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // park the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in.read_data       = (op_ff == OP_READ) ? rdata_ff : 32'd0;
               rsp_payload_in.pam_read_map    = rmap;
               rsp_payload_in.pam_write_map   = wmap;
               rsp_payload_in.mapping_changed = changed_ff;
               rsp_payload_in.smram_enabled   = smram_ff[3];
               rsp_payload_in.smram_open      = smram_ff[6];
               rsp_payload_in.smram_closed    = smram_ff[5];
               rsp_payload_in.smram_conflict  = smram_ff[3] & smram_ff[6] & smram_ff[5];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         pam_ff       <= '{default: 8'h00};
         smram_ff     <= 8'h00;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         pam_ff       <= pam_in;
         smram_ff     <= smram_in;
      end
   end

   // item context, no reset needed
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      wdata_ff       <= wdata_in;
      count_ff       <= count_in;
      byte_idx_ff    <= byte_idx_in;
      tab_idx_ff     <= tab_idx_in;
      rdata_ff       <= rdata_in;
      changed_ff     <= changed_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // checks
   `HBCS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall)
   `HBCS_ASSERT_NEXT(a_rsp_only_from_done, clock, reset,
                     (state_ff != ST_DONE) && !rsp_valid_ff, !rsp_valid_ff)
   `HBCS_ASSERT_NEXT(a_smram_lock_sticks, clock, reset,
                     smram_ff[4] && (state_ff != ST_TABLE), smram_ff[4])
   `HBCS_ASSERT_NOW(a_table_index_range, clock, reset,
                    state_ff == ST_TABLE, tab_idx_ff < TABLE_IDX_W'(TABLE_LEN))

endmodule
